// ===== rtl/msd_pkg.sv =====
// msd_pkg: types, constants and the bias ladder for the mains sync phase dimmer
// no dependencies; imported by every module of the block
`default_nettype none

package msd_pkg;

  typedef enum logic {
    FUNC_CROSSING = 1'b0,
    FUNC_LEVEL    = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    REG_TOLERANCE      = 2'd0,
    REG_SYNC_OFFSET    = 2'd1,
    REG_LOCK_THRESHOLD = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  // status that travels with each result word
  typedef struct packed {
    logic signed [6:0] bias;
    logic              in_tol;
    logic              locked;
  } msd_status_t;

  localparam logic [15:0] RESET_SAMPLE      = 16'h1710;
  localparam logic [9:0]  TOL_RESET         = 10'd32;
  localparam logic [15:0] SYNC_OFFSET_RESET = 16'd570;
  localparam logic [7:0]  LOCK_THR_RESET    = 8'h7F;
  localparam logic [7:0]  LOCK_MAX          = 8'd255;
  localparam logic [7:0]  LEVEL_RESET       = 8'd64;

  localparam logic signed [6:0] BIAS_BIG   = 7'sd48;
  localparam logic signed [6:0] BIAS_MID   = 7'sd8;
  localparam logic signed [6:0] BIAS_SMALL = 7'sd2;
  localparam logic signed [6:0] BIAS_TINY  = 7'sd1;
  localparam logic signed [6:0] BIAS_NONE  = 7'sd0;

  // largest threshold first
  function automatic logic signed [6:0] pick_bias(input logic [15:0] off);
    logic signed [6:0] b;
    if (off > 16'd64) begin
      b = BIAS_BIG;
    end else if (off > 16'd32) begin
      b = BIAS_MID;
    end else if (off > 16'd16) begin
      b = BIAS_SMALL;
    end else if (off > 16'd2) begin
      b = BIAS_TINY;
    end else begin
      b = BIAS_NONE;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msd_sample_cell.sv =====
// msd_sample_cell: one cell of the interval history chain
// holds one sample and hands it to the next cell on shift; uses msd_pkg
`default_nettype none

module msd_sample_cell
  import msd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  logic [15:0] din,
  output logic [15:0] dout
);

  logic [15:0] sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= RESET_SAMPLE;
    end else if (shift) begin
      sample <= din;
    end
  end

  assign dout = sample;

endmodule

`default_nettype wire

// ===== rtl/msd_phase_unit.sv =====
// msd_phase_unit: period times level product stage and the output register
// takes the tracker state one word at a time; uses msd_pkg
`default_nettype none

module msd_phase_unit
  import msd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [15:0] s_average,
  input  logic [7:0]  s_level,
  input  msd_status_t s_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] period,
  output logic [15:0] phase,
  output msd_status_t out_status
);

  logic        s2_valid;
  logic [15:0] s2_average;
  logic [23:0] s2_prod;
  msd_status_t s2_status;
  logic        out_adv;
  logic        s2_adv;

  assign out_adv = !out_valid || !out_stall;
  assign s2_adv  = !s2_valid || out_adv;
  assign s_ready = s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_valid <= s_valid;
      end
      if (out_adv) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s_valid) begin
      s2_average <= s_average;
      s2_prod    <= 24'(s_average) * 24'(s_level);
      s2_status  <= s_status;
    end
    if (out_adv && s2_valid) begin
      period     <= s2_average;
      phase      <= s2_average - s2_prod[23:8];
      out_status <= s2_status;
    end
  end

  // the cut is period * level / 256 with level below 256
  a_phase_le_period: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase <= period)
    else $error("phase above period");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && out_valid && out_stall |=> s2_valid)
    else $error("product stage dropped a word");

endmodule

`default_nettype wire

// ===== rtl/mains_sync_phase_dimmer.sv =====
// mains_sync_phase_dimmer: top level, half-cycle tracker and interval history chain
// uses msd_pkg, msd_sample_cell and msd_phase_unit
//
// Tracks the mains half-cycle from zero-crossing words and gives the triac
// PWM period, phase and bias. One input word is taken every cycle when the
// output side keeps up; each word gives one registered result. The rate is
// set by the tracker update, which does the tolerance check, the history
// chain shift, the running sum and the new average in the cycle a word is
// taken; the bias that follows from a crossing is settled in the next cycle
// and forwarded to a crossing that comes right behind it.
// The interval history is a chain of SAMPLES cells, oldest at the far end.
// Reset puts the block in its start state at once, with no clearing pass.
`default_nettype none

module mains_sync_phase_dimmer
  import msd_pkg::*;
#(
  parameter int SAMPLES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [15:0]        interval,
  input  logic [15:0]        pwm_count,
  input  logic [7:0]         level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        period,
  output logic [15:0]        phase,
  output logic signed [6:0]  bias,
  output logic               in_tolerance,
  output logic               locked
);

  localparam int SHW   = $clog2(SAMPLES);
  localparam bit POW2  = (SAMPLES == (1 << SHW));
  localparam int SUM_W = 16 + SHW;
  localparam int K     = SUM_W + SHW;
  localparam int MW    = SUM_W + 1;
  localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(SAMPLES) * SUM_W'(RESET_SAMPLE);

  // configuration
  logic [9:0]  tolerance;
  logic [15:0] sync_offset;
  logic [7:0]  lock_threshold;

  // tracker state
  logic [SUM_W-1:0] running_sum;
  logic [15:0]      average;
  logic [7:0]       lockdown;
  logic signed [6:0] bias_val;
  logic [7:0]       dim_level;
  logic [15:0]      sync_capture;
  logic             last_in_tol;

  // first stage
  logic s1_valid;
  logic s1_cross;

  logic        accept;
  logic        is_cross;
  logic        ph_ready;
  logic [15:0] win_lo;
  logic [15:0] win_hi;
  logic        in_window;
  logic        take;
  logic        shift;
  logic [15:0] oldest;
  logic [SUM_W-1:0] sum_next;
  logic [15:0] quot;
  logic [15:0] average_next;
  logic signed [6:0] bias_comb;
  logic signed [6:0] bias_eff;
  logic [15:0] off_raw;
  logic [15:0] off_fold;
  logic [15:0] mid;
  msd_status_t s1_status;
  msd_status_t out_status;

  logic [15:0] taps [SAMPLES];

  assign accept   = in_valid && !in_stall;
  assign is_cross = (func_t'(func) == FUNC_CROSSING);
  assign in_stall = s1_valid && !ph_ready;

  // tolerance window wraps at 16 bits
  assign win_lo    = average - 16'(tolerance);
  assign win_hi    = average + 16'(tolerance);
  assign in_window = (interval > win_lo) && (interval < win_hi);
  assign take      = (lockdown > lock_threshold) || in_window;
  assign shift     = accept && is_cross && take;
  assign oldest    = taps[SAMPLES-1];

  // interval history chain
  for (genvar i = 0; i < SAMPLES; i++) begin : g_cells
    if (i == 0) begin : g_head
      msd_sample_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (interval),
        .dout (taps[i])
      );
    end else begin : g_body
      msd_sample_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (taps[i-1]),
        .dout (taps[i])
      );
    end
  end

  always_comb begin
    if (take) begin
      sum_next = running_sum - SUM_W'(oldest) + SUM_W'(interval);
    end else begin
      sum_next = running_sum;
    end
  end

  if (POW2) begin : g_shift_div
    assign quot = sum_next[SHW +: 16];
  end else begin : g_recip_div
    logic [SUM_W+MW-1:0] recip_prod;
    assign recip_prod = (SUM_W+MW)'(sum_next) * (SUM_W+MW)'(RECIP[MW-1:0]);
    assign quot = recip_prod[K +: 16];
  end

  // bias of a crossing still in the first stage is forwarded
  assign bias_eff     = (s1_valid && s1_cross) ? bias_comb : bias_val;
  assign average_next = quot + 16'(bias_eff);

  // sync point against the settled average
  always_comb begin
    off_raw  = sync_capture + average - sync_offset;
    off_fold = (off_raw > average) ? (off_raw - average) : off_raw;
    mid      = {1'b0, average[15:1]};
    if (off_fold < mid) begin
      bias_comb = pick_bias(off_fold);
    end else begin
      bias_comb = -pick_bias(average - off_fold);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOL_RESET;
      sync_offset    <= SYNC_OFFSET_RESET;
      lock_threshold <= LOCK_THR_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_TOLERANCE:      tolerance      <= cfg_data[9:0];
        REG_SYNC_OFFSET:    sync_offset    <= cfg_data;
        REG_LOCK_THRESHOLD: lock_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= SUM_RESET;
      average      <= RESET_SAMPLE;
      lockdown     <= LOCK_MAX;
      bias_val     <= BIAS_NONE;
      dim_level    <= LEVEL_RESET;
      sync_capture <= 16'd0;
      last_in_tol  <= 1'b0;
      s1_valid     <= 1'b0;
      s1_cross     <= 1'b0;
    end else begin
      if (s1_valid && s1_cross) begin
        bias_val <= bias_comb;
      end
      if (accept) begin
        s1_valid <= 1'b1;
        s1_cross <= is_cross;
        if (is_cross) begin
          sync_capture <= pwm_count;
          running_sum  <= sum_next;
          average      <= average_next;
          last_in_tol  <= in_window;
          if (in_window && lockdown != 8'd0) begin
            lockdown <= lockdown - 8'd1;
          end else if (!in_window && lockdown != LOCK_MAX) begin
            lockdown <= lockdown + 8'd1;
          end
        end else begin
          dim_level <= level;
        end
      end else if (ph_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign s1_status.bias   = bias_eff;
  assign s1_status.in_tol = last_in_tol;
  assign s1_status.locked = (lockdown <= lock_threshold);

  msd_phase_unit u_phase (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s1_valid),
    .s_ready   (ph_ready),
    .s_average (average),
    .s_level   (dim_level),
    .s_status  (s1_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .period    (period),
    .phase     (phase),
    .out_status(out_status)
  );

  assign bias         = out_status.bias;
  assign in_tolerance = out_status.in_tol;
  assign locked       = out_status.locked;

  a_level_keeps_average: assert property (@(posedge clk) disable iff (rst)
    accept && !is_cross |=> average == $past(average))
    else $error("level word changed the average");

  a_lockdown_saturates: assert property (@(posedge clk) disable iff (rst)
    accept && is_cross && !in_window && lockdown == LOCK_MAX |=> lockdown == LOCK_MAX)
    else $error("lockdown wrapped past its top");

  a_bias_on_ladder: assert property (@(posedge clk) disable iff (rst)
    bias_val == BIAS_NONE || bias_val == BIAS_TINY || bias_val == -BIAS_TINY ||
    bias_val == BIAS_SMALL || bias_val == -BIAS_SMALL || bias_val == BIAS_MID ||
    bias_val == -BIAS_MID || bias_val == BIAS_BIG || bias_val == -BIAS_BIG)
    else $error("bias off the ladder");

endmodule

`default_nettype wire
